@@ src/bof_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bof_pkg
// Shared constants for the box overlap filter: command codes, default sizes
// and the width of the reported match index.
// ----------------------------------------------------------------------------
package bof_pkg;

  localparam int MAX_REFS_DEF   = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int INDEX_BITS     = 4;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_TEST  = 2'd2;

endpackage : bof_pkg
`default_nettype wire

@@ src/box_overlap_filter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box_overlap_filter_core
// Reference box table with a first-match overlap test for candidate boxes.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   command  | start / busy       | func, box_x, box_y, box_w, box_h
//   result   | done (one cycle)   | overlapped, match_index, out_x..out_h
//
// Clear and load beats finish in the cycle they are taken; busy stays low.
// A test beat keeps busy high while it scans the stored boxes and gives its
// result as busy drops: one table read per cycle from the single memory
// port feeds a four-stage compare pipeline, and the first hit stops the
// scan. An empty table gives its result in the next cycle. No clearing
// pass after reset; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module box_overlap_filter_core
  import bof_pkg::*;
#(
  parameter int MAX_REFS   = MAX_REFS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  wire  [1:0]               func,
  input  wire  [COORD_BITS-1:0]    box_x,
  input  wire  [COORD_BITS-1:0]    box_y,
  input  wire  [COORD_BITS:0]      box_w,
  input  wire  [COORD_BITS:0]      box_h,
  output logic                     done,
  output logic                     overlapped,
  output logic [INDEX_BITS-1:0]    match_index,
  output logic [COORD_BITS-1:0]    out_x,
  output logic [COORD_BITS-1:0]    out_y,
  output logic [COORD_BITS:0]      out_w,
  output logic [COORD_BITS:0]      out_h
);

  localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CNT_W = $clog2(MAX_REFS + 1);
  localparam int P     = COORD_BITS;
  localparam int S     = COORD_BITS + 1;
  localparam int ENT_W = 2 * P + 2 * S;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue_cnt;
  logic [CNT_W-1:0] ret_cnt;
  logic             rd_vld;
  logic [ENT_W-1:0] rd_data;
  logic [ENT_W-1:0] mem [MAX_REFS];

  logic [P-1:0]     cand_x, cand_y;
  logic [S-1:0]     cand_w, cand_h;

  logic             take;
  logic             issue;
  logic             finish;
  logic             ret_last;
  logic             m_vld;
  logic             m_hit;
  logic [IDX_W+INDEX_BITS-1:0] idx_ext;

  assign busy  = (state == S_SCAN);
  assign take  = start && !busy;
  assign out_x = cand_x;
  assign out_y = cand_y;
  assign out_w = cand_w;
  assign out_h = cand_h;

  always_comb begin
    ret_last = (ret_cnt == count - CNT_W'(1));
    finish   = (state == S_SCAN) && m_vld && (m_hit || ret_last);
    issue    = (state == S_SCAN) && (issue_cnt < count) && !finish;
    idx_ext  = {{INDEX_BITS{1'b0}}, ret_cnt[IDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (take && (func == FUNC_LOAD) && (count < CNT_W'(MAX_REFS))) begin
      mem[count[IDX_W-1:0]] <= {box_x, box_y, box_w, box_h};
    end
    rd_data <= mem[issue_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take && (func == FUNC_TEST)) begin
      cand_x <= box_x;
      cand_y <= box_y;
      cand_w <= box_w;
      cand_h <= box_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      issue_cnt   <= '0;
      ret_cnt     <= '0;
      rd_vld      <= 1'b0;
      done        <= 1'b0;
      overlapped  <= 1'b0;
      match_index <= '0;
    end else begin
      done   <= 1'b0;
      rd_vld <= issue;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (func)
              FUNC_CLEAR: count <= '0;
              FUNC_LOAD: begin
                if (count < CNT_W'(MAX_REFS)) begin
                  count <= count + CNT_W'(1);
                end
              end
              FUNC_TEST: begin
                if (count == '0) begin
                  done        <= 1'b1;
                  overlapped  <= 1'b0;
                  match_index <= '0;
                end else begin
                  state     <= S_SCAN;
                  issue_cnt <= '0;
                  ret_cnt   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (finish) begin
            state       <= S_IDLE;
            rd_vld      <= 1'b0;
            done        <= 1'b1;
            overlapped  <= m_hit;
            match_index <= m_hit ? idx_ext[INDEX_BITS-1:0] : '0;
          end else if (m_vld) begin
            ret_cnt <= ret_cnt + CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bof_match #(
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .clk     (clk),
    .rst     (rst),
    .flush   (finish),
    .in_vld  (rd_vld),
    .cand_x  (cand_x),
    .cand_y  (cand_y),
    .cand_w  (cand_w),
    .cand_h  (cand_h),
    .ref_x   (rd_data[ENT_W-1 -: P]),
    .ref_y   (rd_data[2*S+P-1 -: P]),
    .ref_w   (rd_data[2*S-1 -: S]),
    .ref_h   (rd_data[S-1:0]),
    .out_vld (m_vld),
    .out_hit (m_hit)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while scan still running");

  a_empty_table: assert property (@(posedge clk) disable iff (rst)
    (take && (func == FUNC_TEST) && (count == '0)) |=> (done && !overlapped))
    else $error("empty table test did not report kept");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REFS))
    else $error("reference count beyond capacity");

  a_kept_index: assert property (@(posedge clk) disable iff (rst)
    (done && !overlapped) |-> (match_index == '0))
    else $error("kept candidate carries a nonzero index");

endmodule : box_overlap_filter_core
`default_nettype wire

@@ src/bof_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bof_match
// Four-stage overlap test of a candidate box against one reference box:
// edges, intersection and enclosing extents, areas, then the 2*I > E compare.
// ----------------------------------------------------------------------------
module bof_match
  import bof_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     flush,
  input  wire                     in_vld,
  input  wire  [COORD_BITS-1:0]   cand_x,
  input  wire  [COORD_BITS-1:0]   cand_y,
  input  wire  [COORD_BITS:0]     cand_w,
  input  wire  [COORD_BITS:0]     cand_h,
  input  wire  [COORD_BITS-1:0]   ref_x,
  input  wire  [COORD_BITS-1:0]   ref_y,
  input  wire  [COORD_BITS:0]     ref_w,
  input  wire  [COORD_BITS:0]     ref_h,
  output logic                    out_vld,
  output logic                    out_hit
);

  localparam int P = COORD_BITS;
  localparam int E = COORD_BITS + 2;
  localparam int M = 2 * E;

  // stage A
  logic         a_vld;
  logic         a_empty;
  logic [P-1:0] a_ax, a_bx, a_ay, a_by;
  logic [E-1:0] a_axe, a_bxe, a_aye, a_bye;

  // stage B
  logic         b_vld;
  logic         b_nz;
  logic [E-1:0] b_iw, b_ih, b_ex, b_ey;

  // stage C
  logic         c_vld;
  logic         c_nz;
  logic [M-1:0] c_inter, c_encl;

  logic [E-1:0] ix0, ix1, iy0, iy1, lox, hix, loy, hiy;

  always_comb begin
    ix0 = (a_ax > a_bx) ? E'(a_ax) : E'(a_bx);
    iy0 = (a_ay > a_by) ? E'(a_ay) : E'(a_by);
    ix1 = (a_axe < a_bxe) ? a_axe : a_bxe;
    iy1 = (a_aye < a_bye) ? a_aye : a_bye;
    lox = (a_ax < a_bx) ? E'(a_ax) : E'(a_bx);
    loy = (a_ay < a_by) ? E'(a_ay) : E'(a_by);
    hix = (a_axe > a_bxe) ? a_axe : a_bxe;
    hiy = (a_aye > a_bye) ? a_aye : a_bye;
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      c_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      a_vld   <= in_vld;
      b_vld   <= a_vld;
      c_vld   <= b_vld;
      out_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_empty <= (cand_w == '0) || (cand_h == '0) || (ref_w == '0) || (ref_h == '0);
    a_ax    <= cand_x;
    a_bx    <= ref_x;
    a_ay    <= cand_y;
    a_by    <= ref_y;
    a_axe   <= E'(cand_x) + E'(cand_w);
    a_bxe   <= E'(ref_x) + E'(ref_w);
    a_aye   <= E'(cand_y) + E'(cand_h);
    a_bye   <= E'(ref_y) + E'(ref_h);

    b_nz    <= !a_empty && (ix1 > ix0) && (iy1 > iy0);
    b_iw    <= ix1 - ix0;
    b_ih    <= iy1 - iy0;
    b_ex    <= hix - lox;
    b_ey    <= hiy - loy;

    c_nz    <= b_nz;
    c_inter <= M'(b_iw) * M'(b_ih);
    c_encl  <= M'(b_ex) * M'(b_ey);

    out_hit <= c_nz && ({c_inter, 1'b0} > {1'b0, c_encl});
  end

endmodule : bof_match
`default_nettype wire

@@ verif/box_overlap_filter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_overlap_filter_core_tb
// Self-checking bench for the box overlap filter. A queue of clear, load,
// test and spare-code beats feeds a start/busy driver with random gaps; a
// monitor predicts the first-match overlap verdict of each candidate and
// compares every result beat field by field.
// ----------------------------------------------------------------------------
module box_overlap_filter_core_tb
  import bof_pkg::*;
();

  localparam int CB         = COORD_BITS_DEF;
  localparam int MAXR       = MAX_REFS_DEF;
  localparam int ITEM_GOAL  = 1500;
  localparam int CYCLE_CAP  = 600000;
  localparam int TAIL_WAIT  = 40;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB:0]   w;
    logic [CB:0]   h;
  } box_t;

  typedef struct {
    logic [1:0] func;
    box_t       box;
    bit         drain;
    bit         tight;
  } command_t;

  typedef struct {
    logic                  hit;
    logic [INDEX_BITS-1:0] idx;
    box_t                  box;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        func = FUNC_CLEAR;
  logic [CB-1:0]     box_x = '0;
  logic [CB-1:0]     box_y = '0;
  logic [CB:0]       box_w = '0;
  logic [CB:0]       box_h = '0;
  logic              busy;
  logic              done;
  logic              overlapped;
  logic [INDEX_BITS-1:0] match_index;
  logic [CB-1:0]     out_x;
  logic [CB-1:0]     out_y;
  logic [CB:0]       out_w;
  logic [CB:0]       out_h;

  command_t command_q[$];
  verdict_t verdict_q[$];
  box_t     ref_tbl[MAXR];
  int       ref_count = 0;

  bit       cmd_taken = 1'b0;
  bit       tight_run = 1'b0;
  int       gap_left = 0;
  int       cycle_cnt = 0;
  int       err_cnt = 0;
  int       n_items = 0;
  int       n_tests = 0;
  int       n_hits = 0;
  int       n_loads = 0;
  int       n_full = 0;
  int       n_clears = 0;

  box_overlap_filter_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .box_x       (box_x),
    .box_y       (box_y),
    .box_w       (box_w),
    .box_h       (box_h),
    .done        (done),
    .overlapped  (overlapped),
    .match_index (match_index),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_w       (out_w),
    .out_h       (out_h)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic box_t mk_box(int x, int y, int w, int h);
    box_t b;
    b.x = CB'(x);
    b.y = CB'(y);
    b.w = (CB+1)'(w);
    b.h = (CB+1)'(h);
    return b;
  endfunction

  function automatic bit majority_overlap(box_t a, box_t b);
    int     ax1, ay1, bx1, by1, ix0, ix1, iy0, iy1, ex, ey;
    longint inter, encl;
    if (a.w == 0 || a.h == 0 || b.w == 0 || b.h == 0) return 1'b0;
    ax1 = int'(a.x) + int'(a.w);
    ay1 = int'(a.y) + int'(a.h);
    bx1 = int'(b.x) + int'(b.w);
    by1 = int'(b.y) + int'(b.h);
    ix0 = (a.x > b.x) ? int'(a.x) : int'(b.x);
    iy0 = (a.y > b.y) ? int'(a.y) : int'(b.y);
    ix1 = (ax1 < bx1) ? ax1 : bx1;
    iy1 = (ay1 < by1) ? ay1 : by1;
    if (ix1 <= ix0 || iy1 <= iy0) return 1'b0;
    inter = longint'(ix1 - ix0) * longint'(iy1 - iy0);
    ex = ((ax1 > bx1) ? ax1 : bx1) - ((a.x < b.x) ? int'(a.x) : int'(b.x));
    ey = ((ay1 > by1) ? ay1 : by1) - ((a.y < b.y) ? int'(a.y) : int'(b.y));
    encl = longint'(ex) * longint'(ey);
    return 2 * inter > encl;
  endfunction

  function automatic verdict_t judge_candidate(box_t c);
    verdict_t v;
    v.hit = 1'b0;
    v.idx = '0;
    v.box = c;
    for (int i = 0; i < ref_count; i++) begin
      if (majority_overlap(c, ref_tbl[i])) begin
        v.hit = 1'b1;
        v.idx = i[INDEX_BITS-1:0];
        return v;
      end
    end
    return v;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Result beats are checked before a new command beat updates the table.
  always @(posedge clk) begin : monitor
    verdict_t v;
    box_t     b;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no candidate pending");
        err_cnt++;
      end else begin
        v = verdict_q.pop_front();
        check_field("overlapped", v.hit, overlapped);
        check_field("match_index", v.idx, match_index);
        check_field("out_x", v.box.x, out_x);
        check_field("out_y", v.box.y, out_y);
        check_field("out_w", v.box.w, out_w);
        check_field("out_h", v.box.h, out_h);
      end
    end
    cmd_taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      b = mk_box(int'(box_x), int'(box_y), int'(box_w), int'(box_h));
      case (func)
        FUNC_CLEAR: begin
          ref_count = 0;
          n_clears++;
        end
        FUNC_LOAD: begin
          n_loads++;
          if (ref_count < MAXR) begin
            ref_tbl[ref_count] = b;
            ref_count++;
          end else begin
            n_full++;
          end
        end
        FUNC_TEST: begin
          v = judge_candidate(b);
          n_tests++;
          if (v.hit) n_hits++;
          verdict_q.insert(verdict_q.size(), v);
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin : driver
    command_t nxt;
    int       r;
    r = $urandom_range(0, 99);
    if (rst) begin
      start <= 1'b0;
    end else if (start && !cmd_taken) begin
      // hold the beat until busy drops
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (command_q.size() != 0 && command_q[0].drain) begin
      start <= 1'b0;
      if (verdict_q.size() == 0) void'(command_q.pop_front());
    end else if (command_q.size() != 0) begin
      nxt = command_q.pop_front();
      start <= 1'b1;
      func <= nxt.func;
      box_x <= nxt.box.x;
      box_y <= nxt.box.y;
      box_w <= nxt.box.w;
      box_h <= nxt.box.h;
      if (nxt.tight || r < 60) gap_left <= 0;
      else if (r < 93) gap_left <= $urandom_range(1, 3);
      else gap_left <= $urandom_range(8, 40);
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_cmd(logic [1:0] f, box_t b);
    command_t c;
    c.func = f;
    c.box = b;
    c.drain = 1'b0;
    c.tight = tight_run;
    command_q.insert(command_q.size(), c);
    if (f != FUNC_SPARE) n_items++;
  endtask

  task automatic push_drain();
    command_t c;
    c.func = FUNC_CLEAR;
    c.box = mk_box(0, 0, 0, 0);
    c.drain = 1'b1;
    c.tight = 1'b0;
    command_q.insert(command_q.size(), c);
  endtask

  function automatic int rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 1 << CB;
    if (r < 70) return $urandom_range(1, 200);
    if (r < 90) return $urandom_range(1, 1500);
    return $urandom_range(1, 1 << CB);
  endfunction

  function automatic box_t rand_box();
    return mk_box($urandom_range(0, (1 << CB) - 1), $urandom_range(0, (1 << CB) - 1),
                  rand_size(), rand_size());
  endfunction

  function automatic int nudge(int v, int span, int top);
    int n;
    n = v + int'($urandom_range(0, 2 * span)) - span;
    if (n < 0) return 0;
    if (n > top) return top;
    return n;
  endfunction

  function automatic box_t near_box(box_t r);
    int sw, sh;
    sw = int'(r.w) / 4 + 2;
    sh = int'(r.h) / 4 + 2;
    return mk_box(nudge(int'(r.x), sw, (1 << CB) - 1), nudge(int'(r.y), sh, (1 << CB) - 1),
                  nudge(int'(r.w), sw, 1 << CB), nudge(int'(r.h), sh, 1 << CB));
  endfunction

  initial begin : stimulus
    box_t refs[$];
    box_t b;
    int   r, n_ref, n_cand;

    // directed: empty table, full-frame boxes, empty box, spare code
    push_cmd(FUNC_TEST, mk_box(100, 100, 50, 50));
    push_cmd(FUNC_LOAD, mk_box(0, 0, 4096, 4096));
    push_cmd(FUNC_TEST, mk_box(0, 0, 4096, 4096));
    push_cmd(FUNC_TEST, mk_box(0, 0, 0, 4096));
    push_cmd(FUNC_SPARE, mk_box(4095, 4095, 4096, 4096));
    push_cmd(FUNC_CLEAR, mk_box(4095, 4095, 4096, 4096));
    // exact half does not match, just above does, edge contact does not
    push_cmd(FUNC_LOAD, mk_box(10, 10, 10, 10));
    push_cmd(FUNC_TEST, mk_box(10, 10, 5, 10));
    push_cmd(FUNC_TEST, mk_box(10, 10, 6, 10));
    push_cmd(FUNC_TEST, mk_box(20, 10, 10, 10));
    push_cmd(FUNC_LOAD, mk_box(4095, 4095, 4096, 4096));
    push_cmd(FUNC_TEST, mk_box(4095, 4095, 4096, 4096));
    // fill the table, overflow once, hit the last entry
    for (int i = 2; i < MAXR; i++) push_cmd(FUNC_LOAD, mk_box(i * 200, 2000, 100, 100));
    push_cmd(FUNC_LOAD, mk_box(100, 3500, 64, 64));
    push_cmd(FUNC_TEST, mk_box((MAXR - 1) * 200, 2000, 100, 100));
    push_cmd(FUNC_TEST, mk_box(100, 3500, 64, 64));
    push_drain();

    while (n_items < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      tight_run = ($urandom_range(0, 99) < 20);
      if (r < 15) push_drain();
      if (r < 90) begin
        push_cmd(FUNC_CLEAR, rand_box());
        refs.delete();
      end
      r = $urandom_range(0, 99);
      if (r < 5) n_ref = 0;
      else if (r < 60) n_ref = $urandom_range(1, 6);
      else if (r < 85) n_ref = $urandom_range(7, 15);
      else n_ref = $urandom_range(16, 18);
      for (int i = 0; i < n_ref; i++) begin
        b = rand_box();
        push_cmd(FUNC_LOAD, b);
        if (refs.size() < MAXR) refs.insert(refs.size(), b);
      end
      n_cand = $urandom_range(3, 12);
      for (int i = 0; i < n_cand; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60 && refs.size() != 0) begin
          push_cmd(FUNC_TEST, near_box(refs[$urandom_range(0, refs.size() - 1)]));
        end else if (r < 85) begin
          push_cmd(FUNC_TEST, rand_box());
        end else if (r < 95) begin
          b = rand_box();
          if (r < 90) b.w = 0;
          else b.h = 0;
          push_cmd(FUNC_TEST, b);
        end else begin
          push_cmd(FUNC_SPARE, rand_box());
        end
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (command_q.size() != 0 || start || verdict_q.size() != 0);
    repeat (TAIL_WAIT) @(negedge clk);

    if (verdict_q.size() != 0) begin
      $error("%0d candidate results never arrived", verdict_q.size());
      err_cnt++;
    end
    $display("Covered %0d candidate tests: %0d dropped as overlapping, %0d kept.",
             n_tests, n_hits, n_tests - n_hits);
    $display("Table traffic: %0d loads (%0d beyond capacity), %0d clears, %0d cycles.",
             n_loads, n_full, n_clears, cycle_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
